@@ rtl/core/wsc_pkg.sv @@
// shared types and constants for the lattice cell wrap
`timescale 1ns / 1ps
package wsc_pkg;
  localparam int unsigned NumRegs = 6;
  localparam int unsigned RegWidth = 63;
  localparam int unsigned IdxWidth = 3;
  localparam int unsigned PosFrac = 10;
  localparam int unsigned InvFrac = 18;
  localparam int unsigned LatFrac = PosFrac + InvFrac;
  localparam int unsigned NumShift = 8;

  // register indexes
  typedef enum logic [IdxWidth-1:0] {
    RegBasisA = 3'd0,
    RegBasisB = 3'd1,
    RegBasisC = 3'd2,
    RegInvA   = 3'd3,
    RegInvB   = 3'd4,
    RegInvC   = 3'd5
  } reg_idx_e;

  // which basis vectors each corner shift subtracts: bit0 a, bit1 b, bit2 c
  function automatic logic [2:0] shift_use(input logic [2:0] k);
    logic [2:0] u;
    case (k)
      3'd0:    u = 3'b000;
      3'd1:    u = 3'b001;
      3'd2:    u = 3'b010;
      3'd3:    u = 3'b100;
      3'd4:    u = 3'b011;
      3'd5:    u = 3'b110;
      3'd6:    u = 3'b101;
      default: u = 3'b111;
    endcase
    return u;
  endfunction
endpackage

@@ rtl/core/wigner_seitz_cell_wrap.sv @@
// lattice cell wrap: fractional coordinates, rebuild, nearest corner search
// each input transaction passes through every stage to its result on the output register
// throughput: one position per cycle; every stage advances when the output can move
// the pipeline is a chain of registers with valid bits, stalled as a whole
// reset: valid bits and all six lattice registers clear (everything wraps to 0)
`timescale 1ns / 1ps
module wigner_seitz_cell_wrap #(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned COEF_WIDTH  = 21
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x, pos_y, pos_z, zero fill to bytes
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // wrapped_x, wrapped_y, wrapped_z, chosen_shift, zero fill to bytes
  output logic [((3*COORD_WIDTH+3+7)/8)*8-1:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [wsc_pkg::IdxWidth-1:0] cfg_index_i,
  input  logic [wsc_pkg::RegWidth-1:0] cfg_data_i
);
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned KW = COEF_WIDTH;
  localparam int unsigned LF = wsc_pkg::LatFrac;
  localparam int unsigned OutW = ((3*CW+3+7)/8)*8;
  localparam int unsigned ProdW = CW + KW;          // coef * pos
  localparam int unsigned SumW = ProdW + 2;         // sum of three
  localparam int unsigned RProdW = KW + LF + 1;     // coef * unsigned fraction
  localparam int unsigned RSumW = RProdW + 2;
  localparam int unsigned RW = RSumW - LF;          // rebuilt coordinate
  localparam int unsigned CandW = RW + 2;           // after subtracting up to three
  localparam int unsigned SqW = 2*CandW;
  localparam int unsigned NormW = SqW + 2;
  localparam int unsigned NStg = 8;

  typedef logic signed [KW-1:0] coef_t;

  // configuration registers
  logic [wsc_pkg::RegWidth-1:0] regs_q [wsc_pkg::NumRegs];
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < wsc_pkg::NumRegs; r++) regs_q[r] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wsc_pkg::RegBasisA: regs_q[0] <= cfg_data_i;
        wsc_pkg::RegBasisB: regs_q[1] <= cfg_data_i;
        wsc_pkg::RegBasisC: regs_q[2] <= cfg_data_i;
        wsc_pkg::RegInvA:   regs_q[3] <= cfg_data_i;
        wsc_pkg::RegInvB:   regs_q[4] <= cfg_data_i;
        wsc_pkg::RegInvC:   regs_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // field views: bas[i][j] = component i of vector j, inv[i][j] = row i col j
  coef_t bas [3][3];
  coef_t inv [3][3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        bas[i][j] = coef_t'(regs_q[j][i*KW +: KW]);
        inv[i][j] = coef_t'(regs_q[3+i][j*KW +: KW]);
      end
    end
  end

  // global pipeline enable
  logic [NStg-1:0] v_q;
  logic adv;
  assign adv = !v_q[NStg-1] || m_axis_tready;
  assign s_axis_tready = adv;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[NStg-2:0], s_axis_tvalid};
  end

  // stage 1: input register
  logic signed [CW-1:0] p_q [3];
  // stage 2: nine products of inverse times position
  logic signed [ProdW-1:0] sp_q [3][3];
  // stage 3: fractional lattice coordinates
  logic [LF-1:0] f_q [3];
  // stage 4: nine products of basis times fraction
  logic signed [RProdW-1:0] rp_q [3][3];
  // stage 5: rebuilt position
  logic signed [RW-1:0] r_q [3];
  // stage 6: candidates and squared components
  logic signed [CandW-1:0] c_q [wsc_pkg::NumShift][3];
  logic [SqW-1:0] sq_q [wsc_pkg::NumShift][3];
  // stage 7: candidates and norms
  logic signed [CandW-1:0] c2_q [wsc_pkg::NumShift][3];
  logic [NormW-1:0] n_q [wsc_pkg::NumShift];
  // stage 8: output register
  logic signed [CW-1:0] w_q [3];
  logic [2:0] k_q;

  logic [LF-1:0] f_d [3];
  logic signed [RW-1:0] r_d [3];
  logic signed [CandW-1:0] c_d [wsc_pkg::NumShift][3];
  logic [2:0] k_d;
  logic signed [CW-1:0] w_d [3];

  always_comb begin
    logic signed [SumW-1:0] s;
    logic signed [RSumW-1:0] a;
    logic [2:0] u;
    logic [NormW-1:0] n1 [4];
    logic [2:0] k1 [4];
    logic [NormW-1:0] n2 [2];
    logic [2:0] k2 [2];
    logic signed [CandW-1:0] bv;
    for (int i = 0; i < 3; i++) begin
      s = SumW'(sp_q[i][0]) + SumW'(sp_q[i][1]) + SumW'(sp_q[i][2]);
      f_d[i] = s[LF-1:0];
      a = RSumW'(rp_q[i][0]) + RSumW'(rp_q[i][1]) + RSumW'(rp_q[i][2]);
      r_d[i] = a[RSumW-1:LF];
    end
    for (int k = 0; k < wsc_pkg::NumShift; k++) begin
      u = wsc_pkg::shift_use(3'(k));
      for (int i = 0; i < 3; i++) begin
        c_d[k][i] = CandW'(r_q[i])
                  - (u[0] ? CandW'(bas[i][0]) : '0)
                  - (u[1] ? CandW'(bas[i][1]) : '0)
                  - (u[2] ? CandW'(bas[i][2]) : '0);
      end
    end
    // pairwise minimum tree, the lower index keeps a tie
    for (int j = 0; j < 4; j++) begin
      if (n_q[2*j+1] < n_q[2*j]) begin
        n1[j] = n_q[2*j+1];
        k1[j] = 3'(2*j+1);
      end else begin
        n1[j] = n_q[2*j];
        k1[j] = 3'(2*j);
      end
    end
    for (int j = 0; j < 2; j++) begin
      if (n1[2*j+1] < n1[2*j]) begin
        n2[j] = n1[2*j+1];
        k2[j] = k1[2*j+1];
      end else begin
        n2[j] = n1[2*j];
        k2[j] = k1[2*j];
      end
    end
    k_d = (n2[1] < n2[0]) ? k2[1] : k2[0];
    for (int i = 0; i < 3; i++) begin
      bv = c2_q[k_d][i];
      if (bv > CandW'(signed'({1'b0, {(CW-1){1'b1}}})))
        w_d[i] = {1'b0, {(CW-1){1'b1}}};
      else if (bv < CandW'(signed'({1'b1, {(CW-1){1'b0}}})))
        w_d[i] = {1'b1, {(CW-1){1'b0}}};
      else
        w_d[i] = bv[CW-1:0];
    end
  end

  // datapath registers, all advance together
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= s_axis_tdata[i*CW +: CW];
        for (int j = 0; j < 3; j++) begin
          sp_q[i][j] <= ProdW'(inv[i][j]) * ProdW'(p_q[j]);
          rp_q[i][j] <= RProdW'(bas[i][j]) * RProdW'(signed'({1'b0, f_q[j]}));
        end
        f_q[i] <= f_d[i];
        r_q[i] <= r_d[i];
        w_q[i] <= w_d[i];
      end
      for (int k = 0; k < wsc_pkg::NumShift; k++) begin
        for (int i = 0; i < 3; i++) begin
          c_q[k][i] <= c_d[k][i];
          sq_q[k][i] <= SqW'(c_d[k][i] * c_d[k][i]);
          c2_q[k][i] <= c_q[k][i];
        end
        n_q[k] <= NormW'(sq_q[k][0]) + NormW'(sq_q[k][1]) + NormW'(sq_q[k][2]);
      end
      k_q <= k_d;
    end
  end

  assign m_axis_tvalid = v_q[NStg-1];
  assign m_axis_tdata = OutW'({k_q, w_q[2], w_q[1], w_q[0]});

`ifndef SYNTHESIS
  // a held result must not be replaced or dropped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  // input is taken whenever the output can move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("pipeline stalled with free output");
  // an accepted item enters the first stage with its valid bit
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && v_q[NStg-2:0] == '0 |=> v_q[0])
    else $error("accepted item lost its valid bit");
`endif
endmodule
